### rtl/lfpmm_pkg.sv
// Package: widths and reciprocal constants for the line-follow PID motor mixer.
`timescale 1ns / 1ps

package lfpmm_pkg;

  localparam int ERR_W   = 12;  // line error
  localparam int DERIV_W = 13;  // error change
  localparam int SUM_W   = 32;  // running error sum
  localparam int SPEED_W = 8;   // wheel levels and base speed
  localparam int POWER_W = 23;  // raw PID sum

  // Term widths after the constant divides
  localparam int Q10_W  = 9;    // error / 10, |value| <= 204
  localparam int Q600_W = 23;   // sum / 600, |value| <= 3579139
  localparam int DTERM_W = 15;  // (deriv * 7) / 2, |value| <= 14336

  // floor(x / 10) = (x * RECIP10) >> RECIP10_SH, exact for x < 4096
  localparam int RECIP10_W  = 12;
  localparam logic [RECIP10_W-1:0] RECIP10 = 12'd3277;
  localparam int RECIP10_SH = 15;

  // sum / 600 = ((x >> 3) * RECIP75) >> RECIP75_SH, exact for x < 2^32
  localparam int RECIP75_W  = 30;
  localparam logic [RECIP75_W-1:0] RECIP75 = 30'd916259690;
  localparam int RECIP75_SH = 36;

endpackage

### rtl/line_follow_pid_motor_mix_top.sv
// Top level: line-follow PID steering mixer with a three-stage pipeline.
`timescale 1ns / 1ps

// Takes one signed line error word per cycle while out_stall is low and
// returns one word per error: left and right wheel levels, the raw PID
// power and the error change, through the stage one, stage two and output
// registers. Stage one updates the previous error and the saturating error
// sum as the word is taken, stage two divides the terms by their constants
// (reciprocal multiplies), stage three adds them, clamps to +/- the cruise
// level and mixes the wheels. Write the cruise level (reset 0) only while
// no word is in flight.
module line_follow_pid_motor_mix_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [lfpmm_pkg::SPEED_W-1:0]       cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lfpmm_pkg::ERR_W-1:0]  in_line_error,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lfpmm_pkg::SPEED_W-1:0]       out_left_speed,
  output logic [lfpmm_pkg::SPEED_W-1:0]       out_right_speed,
  output logic signed [lfpmm_pkg::POWER_W-1:0] out_power_difference,
  output logic signed [lfpmm_pkg::DERIV_W-1:0] out_error_change
);
  import lfpmm_pkg::*;

  logic [SPEED_W-1:0] cruise_level_r;

  // controller state
  logic signed [ERR_W-1:0] prev_err_r;
  logic signed [SUM_W-1:0] err_sum_r;

  // pipeline valids and enables
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic en1, en2, en3, in_accept;

  // stage 1 payload
  logic signed [ERR_W-1:0]   s1_err_r;
  logic signed [DERIV_W-1:0] s1_deriv_r;
  logic signed [SUM_W-1:0]   s1_sum_r;

  // stage 2 payload
  logic signed [Q10_W-1:0]   s2_q10_r;
  logic signed [Q600_W-1:0]  s2_q600_r;
  logic signed [DTERM_W-1:0] s2_dterm_r;
  logic signed [DERIV_W-1:0] s2_deriv_r;

  // output register
  logic [SPEED_W-1:0]        out_left_r, out_right_r;
  logic signed [POWER_W-1:0] out_power_r;
  logic signed [DERIV_W-1:0] out_deriv_r;

  // stage 1 logic
  logic signed [DERIV_W-1:0] deriv_nxt;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_nxt;

  // stage 2 logic
  logic                            err_neg, sum_neg;
  logic [ERR_W-1:0]                err_mag;
  logic [ERR_W+RECIP10_W-1:0]      prod10;
  logic [Q10_W-1:0]                q10_mag;
  logic [SUM_W-1:0]                sum_mag;
  logic [SUM_W-3-1:0]              sum_div8;
  logic [SUM_W-3+RECIP75_W-1:0]    prod75;
  logic [Q600_W-1:0]               q600_mag;
  logic signed [DERIV_W+2:0]       d7;
  logic signed [DERIV_W+2:0]       d7_adj;
  logic signed [Q10_W-1:0]         q10_nxt;
  logic signed [Q600_W-1:0]        q600_nxt;
  logic signed [DTERM_W-1:0]       dterm_nxt;

  // stage 3 logic
  logic signed [POWER_W:0]   power_wide;
  logic signed [SPEED_W+1:0] lim;
  logic signed [SPEED_W+1:0] clamped;
  logic [SPEED_W+1:0]        left_wide, right_wide;

  // Handshake: each stage advances when the one after it is free or draining
  assign en3       = !out_valid_r || !out_stall;
  assign en2       = !s2_valid_r || en3;
  assign en1       = !s1_valid_r || en2;
  assign in_stall  = !en1;
  assign in_accept = in_valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cruise_level_r <= '0;
      prev_err_r     <= '0;
      err_sum_r      <= '0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cruise_level_r <= cfg_wr_data;
      end
      if (in_accept) begin
        prev_err_r <= in_line_error;
        err_sum_r  <= sum_nxt;
      end
      if (en1) begin
        s1_valid_r <= in_valid;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage 1: derivative and saturating sum, taken straight off the input
  always_comb begin
    deriv_nxt = DERIV_W'(in_line_error) - DERIV_W'(prev_err_r);
    sum_wide  = (SUM_W+1)'(err_sum_r) + (SUM_W+1)'(in_line_error);
    // clip at the 32-bit limits when the top two bits disagree
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_err_r   <= in_line_error;
      s1_deriv_r <= deriv_nxt;
      s1_sum_r   <= sum_nxt;
    end
  end

  // Stage 2: truncating divides on magnitudes, sign restored after
  always_comb begin
    err_neg   = s1_err_r[ERR_W-1];
    err_mag   = err_neg ? ERR_W'(-s1_err_r) : ERR_W'(s1_err_r);
    prod10    = (ERR_W+RECIP10_W)'(err_mag) * (ERR_W+RECIP10_W)'(RECIP10);
    q10_mag   = Q10_W'(prod10 >> RECIP10_SH);
    q10_nxt   = err_neg ? -$signed(q10_mag) : $signed(q10_mag);

    sum_neg   = s1_sum_r[SUM_W-1];
    sum_mag   = sum_neg ? SUM_W'(-s1_sum_r) : SUM_W'(s1_sum_r);
    sum_div8  = sum_mag[SUM_W-1:3];
    prod75    = (SUM_W-3+RECIP75_W)'(sum_div8) * (SUM_W-3+RECIP75_W)'(RECIP75);
    q600_mag  = Q600_W'(prod75 >> RECIP75_SH);
    q600_nxt  = sum_neg ? -$signed(q600_mag) : $signed(q600_mag);

    // times 7 as times 8 minus one, then halve toward zero
    d7        = ((DERIV_W+3)'(s1_deriv_r) <<< 3) - (DERIV_W+3)'(s1_deriv_r);
    d7_adj    = d7 + (DERIV_W+3)'({1'b0, d7[DERIV_W+2]});
    dterm_nxt = DTERM_W'(d7_adj >>> 1);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_q10_r   <= q10_nxt;
      s2_q600_r  <= q600_nxt;
      s2_dterm_r <= dterm_nxt;
      s2_deriv_r <= s1_deriv_r;
    end
  end

  // Stage 3: add terms, clamp to base speed, slow down one wheel
  always_comb begin
    power_wide = (POWER_W+1)'(s2_q10_r) + (POWER_W+1)'(s2_q600_r)
               + (POWER_W+1)'(s2_dterm_r);
    lim        = $signed({2'b00, cruise_level_r});
    if (power_wide > (POWER_W+1)'(lim)) begin
      clamped = lim;
    end else if (power_wide < -(POWER_W+1)'(lim)) begin
      clamped = -lim;
    end else begin
      clamped = (SPEED_W+2)'(power_wide);
    end
    if (clamped[SPEED_W+1]) begin
      left_wide  = lim + clamped;
      right_wide = lim;
    end else begin
      left_wide  = lim;
      right_wide = lim - clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_left_r  <= left_wide[SPEED_W-1:0];
      out_right_r <= right_wide[SPEED_W-1:0];
      out_power_r <= power_wide[POWER_W-1:0];
      out_deriv_r <= s2_deriv_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_left_speed       = out_left_r;
  assign out_right_speed      = out_right_r;
  assign out_power_difference = out_power_r;
  assign out_error_change     = out_deriv_r;

endmodule

### rtl/lfpmm_checker.sv
// Checker: port-level properties of the line-follow PID motor mixer, and its bind.
`timescale 1ns / 1ps

module lfpmm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [lfpmm_pkg::SPEED_W-1:0]        out_left_speed,
  input logic [lfpmm_pkg::SPEED_W-1:0]        out_right_speed,
  input logic signed [lfpmm_pkg::POWER_W-1:0] out_power_difference,
  input logic signed [lfpmm_pkg::DERIV_W-1:0] out_error_change
);
  import lfpmm_pkg::*;

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_speed)
      && $stable(out_right_speed) && $stable(out_power_difference)
      && $stable(out_error_change))
    else $error("stalled result word changed");

  // positive power slows the right wheel, negative the left
  a_mix_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_power_difference[POWER_W-1] ? out_left_speed <= out_right_speed
                                                   : out_left_speed >= out_right_speed))
    else $error("wrong wheel slowed for power sign");

  // zero power leaves the wheels equal
  a_mix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_power_difference == '0 |-> out_left_speed == out_right_speed)
    else $error("wheels differ at zero power");

endmodule

bind line_follow_pid_motor_mix_top lfpmm_checker u_lfpmm_checker (.*);
